FILE: src/itda_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itda_pkg
// Shared types, constants and the power-of-ten table for the
// integer to decimal ascii converter.
// ---------------------------------------------------------------------------
package itda_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int POS_W       = 4;
    localparam int STEP_W      = 2;
    localparam int MULT_W      = 34;

    localparam logic [POS_W-1:0]  TOP_POS   = POS_W'(9);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(3);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_TRIAL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                ge;
        logic [VALUE_W-1:0]  diff;
    } t_trial_res;

    typedef struct packed {
        logic [CHAR_W-1:0]   code;
        logic                last;
    } t_char;

    function automatic logic [MULT_W-1:0] pow10(input logic [POS_W-1:0] pos);
        logic [MULT_W-1:0] p;
        case (pos)
            4'd0:    p = MULT_W'(64'd1);
            4'd1:    p = MULT_W'(64'd10);
            4'd2:    p = MULT_W'(64'd100);
            4'd3:    p = MULT_W'(64'd1000);
            4'd4:    p = MULT_W'(64'd10000);
            4'd5:    p = MULT_W'(64'd100000);
            4'd6:    p = MULT_W'(64'd1000000);
            4'd7:    p = MULT_W'(64'd10000000);
            4'd8:    p = MULT_W'(64'd100000000);
            4'd9:    p = MULT_W'(64'd1000000000);
            default: p = MULT_W'(64'd1);
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

FILE: src/itda_trial_sub.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itda_trial_sub
// Shared compare and subtract unit: tests the remainder against
// 10^pos scaled by 8, 4, 2 or 1 and gives the reduced remainder.
// ---------------------------------------------------------------------------
module itda_trial_sub (
    input  wire logic [itda_pkg::VALUE_W-1:0] i_rem,
    input  wire logic [itda_pkg::POS_W-1:0]   i_pos,
    input  wire logic [itda_pkg::STEP_W-1:0]  i_step,
    output itda_pkg::t_trial_res              o_res
);

    logic [itda_pkg::MULT_W-1:0] mult;
    logic [itda_pkg::MULT_W-1:0] rem_ext;

    assign mult    = itda_pkg::pow10(i_pos) << (itda_pkg::LAST_STEP - i_step);
    assign rem_ext = itda_pkg::MULT_W'(i_rem);

    always_comb begin
        o_res.ge   = (rem_ext >= mult);
        o_res.diff = i_rem - mult[itda_pkg::VALUE_W-1:0];
    end

endmodule
`default_nettype wire

FILE: src/itda_out_buf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itda_out_buf
// Output register for characters; takes a new item while the held one
// is being taken downstream.
// ---------------------------------------------------------------------------
module itda_out_buf (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire itda_pkg::t_char             i_data,
    output logic                             o_ready,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [itda_pkg::CHAR_W-1:0]      o_char_code,
    output logic                             o_last_char
);

    logic            r_valid;
    logic            n_valid;
    itda_pkg::t_char r_data;

    assign o_ready = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_push) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_char_code = r_data.code;
    assign o_last_char = r_data.last;

endmodule
`default_nettype wire

FILE: src/integer_to_decimal_ascii.sv
`default_nettype none
// input: a new value is accepted only in the idle state, after its last character is
// pushed; each of ten digit positions takes four compare and subtract steps in the
// shared unit and then the emit state, which skips leading zero digits
// output stall, while a character is held, holds the sequencer in its sign or emit state
// reset: synchronous, active low; clears the sequencer and the output valid
// ---------------------------------------------------------------------------
// integer_to_decimal_ascii
// Signed 32-bit integer to decimal ascii text, most significant character
// first, with a leading minus for negative values and a last-character mark.
// ---------------------------------------------------------------------------
module integer_to_decimal_ascii (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic signed [itda_pkg::VALUE_W-1:0] i_value,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [itda_pkg::CHAR_W-1:0]       o_char_code,
    output logic                              o_last_char
);

    itda_pkg::t_state r_state, n_state;

    logic [itda_pkg::VALUE_W-1:0] r_rem, n_rem;
    logic [itda_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [itda_pkg::STEP_W-1:0]  r_step, n_step;
    logic [itda_pkg::DIGIT_W-1:0] r_digit, n_digit;
    logic                         r_started, n_started;

    logic                         accept;
    logic                         negative;
    logic [itda_pkg::VALUE_W-1:0] raw;
    logic [itda_pkg::VALUE_W-1:0] mag;
    logic                         skip_zero;
    logic                         ob_ready;
    logic                         push;
    itda_pkg::t_char              push_data;
    itda_pkg::t_trial_res         trial;

    assign o_in_stall = (r_state != itda_pkg::ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign raw        = i_value;
    assign negative   = raw[itda_pkg::VALUE_W-1];
    assign mag        = negative ? (itda_pkg::VALUE_W'(0) - raw) : raw;
    assign skip_zero  = (r_digit == '0) && !r_started && (r_pos != '0);

    itda_trial_sub u_trial (
        .i_rem  (r_rem),
        .i_pos  (r_pos),
        .i_step (r_step),
        .o_res  (trial)
    );

    itda_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (push_data),
        .o_ready     (ob_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            itda_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = negative ? itda_pkg::ST_SIGN : itda_pkg::ST_TRIAL;
                end
            end
            itda_pkg::ST_SIGN: begin
                if (ob_ready) begin
                    n_state = itda_pkg::ST_TRIAL;
                end
            end
            itda_pkg::ST_TRIAL: begin
                if (r_step == itda_pkg::LAST_STEP) begin
                    n_state = itda_pkg::ST_EMIT;
                end
            end
            itda_pkg::ST_EMIT: begin
                if (skip_zero) begin
                    n_state = itda_pkg::ST_TRIAL;
                end else if (ob_ready) begin
                    n_state = (r_pos == '0) ? itda_pkg::ST_IDLE : itda_pkg::ST_TRIAL;
                end
            end
            default: n_state = itda_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_rem          = r_rem;
        n_pos          = r_pos;
        n_step         = r_step;
        n_digit        = r_digit;
        n_started      = r_started;
        push           = 1'b0;
        push_data.code = itda_pkg::CHAR_MINUS;
        push_data.last = 1'b0;
        case (r_state)
            itda_pkg::ST_IDLE: begin
                if (accept) begin
                    n_rem     = mag;
                    n_pos     = itda_pkg::TOP_POS;
                    n_step    = '0;
                    n_digit   = '0;
                    n_started = 1'b0;
                end
            end
            itda_pkg::ST_SIGN: begin
                push = ob_ready;
            end
            itda_pkg::ST_TRIAL: begin
                n_step  = r_step + itda_pkg::STEP_W'(1);
                n_digit = {r_digit[itda_pkg::DIGIT_W-2:0], trial.ge};
                if (trial.ge) begin
                    n_rem = trial.diff;
                end
            end
            itda_pkg::ST_EMIT: begin
                push_data.code = itda_pkg::CHAR_ZERO + itda_pkg::CHAR_W'(r_digit);
                push_data.last = (r_pos == '0);
                if (skip_zero) begin
                    n_pos   = r_pos - itda_pkg::POS_W'(1);
                    n_step  = '0;
                    n_digit = '0;
                end else if (ob_ready) begin
                    push      = 1'b1;
                    n_started = 1'b1;
                    n_pos     = r_pos - itda_pkg::POS_W'(1);
                    n_step    = '0;
                    n_digit   = '0;
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_pos     <= n_pos;
        r_step    <= n_step;
        r_digit   <= n_digit;
        r_started <= n_started;
    end

endmodule
`default_nettype wire
